>>> rtl/quantized_vertex_dedup_macros.svh
// Assertion macros shared by the vertex dedup RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef QUANTIZED_VERTEX_DEDUP_MACROS_SVH
`define QUANTIZED_VERTEX_DEDUP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QVD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define QVD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/qvd_pkg.sv
// Package for the quantized vertex dedup block: sizes, constants and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package qvd_pkg;

	localparam int DEF_TABLE_SLOTS = 8192;
	localparam int DEF_MAX_UNIQUE  = 4096;
	localparam int DEF_FIELD_BITS  = 21;

	localparam int COORD_W = 32;
	localparam int IDX_W   = 12;
	localparam int SHIFT_W = 5;
	localparam int IN_DATA_W  = 3 * COORD_W;
	localparam int OUT_FIELDS_W = IDX_W + 2 + 6 * COORD_W;
	localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [SHIFT_W-1:0] QUANT_SHIFT_RESET = 5'd4;

	// Golden-ratio multiplier of the slot hash.
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam int HASH_XOR_SHIFT = 29;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec3_t;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		S_SWEEP = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_PROBE = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

endpackage

>>> rtl/qvd_hash.sv
// Key and slot pipeline: quantizes a position, packs the key, hashes to a slot.
// Four register stages; depends on qvd_pkg.
`timescale 1ns / 1ps

module qvd_hash #(
	parameter int FIELD_BITS = qvd_pkg::DEF_FIELD_BITS,
	parameter int SLOT_W     = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  qvd_pkg::vec3_t             pos,
	input  logic [qvd_pkg::SHIFT_W-1:0] quant_shift,
	output logic                       done,
	output logic [3*FIELD_BITS-1:0]    key,
	output logic [SLOT_W-1:0]          slot
);
	import qvd_pkg::*;

	localparam int KEY_W = 3 * FIELD_BITS;

	logic [2:0]           vld_q;
	logic [COORD_W-1:0]   mag_s1 [3];
	logic [2:0]           neg_s1;
	logic [KEY_W-1:0]     key_s2;
	logic [63:0]          key64;
	logic [63:0]          p0_s3;
	logic [12:0]          p1_s3;
	logic [12:0]          p2_s3;
	logic [KEY_W-1:0]     key_s3;
	logic [44:0]          prod;
	logic [SLOT_W-1:0]    slot_s4;
	logic [KEY_W-1:0]     key_s4;
	logic [KEY_W-1:0]     key_c;
	logic                 vld_s4;

	// Stage valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s4 <= 1'b0;
		end else begin
			vld_q  <= {vld_q[1:0], start};
			vld_s4 <= vld_q[2];
		end
	end

	// Stage 1: magnitude shifted toward zero.
	always_ff @(posedge clk) begin
		mag_s1[0] <= (pos.x[COORD_W-1] ? (-pos.x) : pos.x) >> quant_shift;
		mag_s1[1] <= (pos.y[COORD_W-1] ? (-pos.y) : pos.y) >> quant_shift;
		mag_s1[2] <= (pos.z[COORD_W-1] ? (-pos.z) : pos.z) >> quant_shift;
		neg_s1    <= {pos.z[COORD_W-1], pos.y[COORD_W-1], pos.x[COORD_W-1]};
	end

	// Stage 2: restore sign and pack the low field bits.
	always_comb begin
		key_c = '0;
		for (int i = 0; i < 3; i++) begin
			key_c[i*FIELD_BITS +: FIELD_BITS] =
				neg_s1[i] ? FIELD_BITS'(-mag_s1[i]) : FIELD_BITS'(mag_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		key_s2 <= key_c;
	end

	// Stage 3: partial products of the low 45 bits of key times the multiplier.
	assign key64 = 64'(key_s2);

	always_ff @(posedge clk) begin
		p0_s3  <= 64'(key64[31:0]) * 64'(HASH_MULT[31:0]);
		p1_s3  <= 13'(key64[12:0] * HASH_MULT[44:32]);
		p2_s3  <= 13'(key64[44:32] * HASH_MULT[12:0]);
		key_s3 <= key_s2;
	end

	// Stage 4: sum the partials and fold the high bits into the slot.
	assign prod = p0_s3[44:0] + {p1_s3 + p2_s3, 32'd0};

	always_ff @(posedge clk) begin
		slot_s4 <= prod[SLOT_W-1:0] ^ prod[HASH_XOR_SHIFT +: SLOT_W];
		key_s4  <= key_s3;
	end

	assign done = vld_s4;
	assign key  = key_s4;
	assign slot = slot_s4;

endmodule

>>> rtl/qvd_table.sv
// Hash table memory: one synchronous write port and one registered read port.
// Depends on qvd_pkg for the default slot count.
`timescale 1ns / 1ps

module qvd_table #(
	parameter int SLOTS   = qvd_pkg::DEF_TABLE_SLOTS,
	parameter int ENTRY_W = 76
) (
	input  logic                     clk,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	output logic [ENTRY_W-1:0]       rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  logic [ENTRY_W-1:0]       wr_data
);
	import qvd_pkg::*;

	logic [ENTRY_W-1:0] mem [SLOTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/quantized_vertex_dedup.sv
// An input beat is captured, hashed to a key and slot, then probed linearly
// from that slot; when clear_table is set, a sweep of every slot comes first.
// Vertices are processed one at a time; the linear probe reads one table
// slot per cycle from the single read port. A new input beat is taken while
// the previous result waits. Reset clears count and box, then a sweep
// invalidates every slot before the first beat is taken.
`timescale 1ns / 1ps

module quantized_vertex_dedup #(
	parameter int TABLE_SLOTS = qvd_pkg::DEF_TABLE_SLOTS,
	parameter int MAX_UNIQUE  = qvd_pkg::DEF_MAX_UNIQUE,
	parameter int FIELD_BITS  = qvd_pkg::DEF_FIELD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [qvd_pkg::IN_DATA_W-1:0]   s_tdata,  // coord_x, coord_y, coord_z
	input  logic [0:0]                      s_tuser,  // clear_table
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// vertex_index, is_new, overflow, box_min_x/y/z, box_max_x/y/z, zero pad
	output logic [qvd_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qvd_pkg::SHIFT_W-1:0]     cfg_data  // quant_shift
);
	import qvd_pkg::*;

	`include "quantized_vertex_dedup_macros.svh"

	localparam int SLOT_W  = $clog2(TABLE_SLOTS);
	localparam int KEY_W   = 3 * FIELD_BITS;
	localparam int ENTRY_W = 1 + KEY_W + IDX_W;
	localparam int CNT_W   = $clog2(MAX_UNIQUE + 1);

	state_t               state_q;
	logic [SHIFT_W-1:0]   quant_shift_q;
	vec3_t                pos_q;
	logic                 pos_q_pending_q;
	logic                 hash_start_q;
	logic                 hash_done;
	logic [KEY_W-1:0]     hash_key;
	logic [SLOT_W-1:0]    hash_slot;
	logic [KEY_W-1:0]     key_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    probes_q;
	logic [SLOT_W-1:0]    sweep_q;
	logic                 sweep_last;
	logic [CNT_W-1:0]     count_q;
	vec3_t                bmin_q;
	vec3_t                bmax_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic                 res_new_q;
	logic                 res_ovf_q;
	logic [SLOT_W-1:0]    rd_addr;
	logic [ENTRY_W-1:0]   rd_data;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic                 ent_valid;
	logic [KEY_W-1:0]     ent_key;
	logic [IDX_W-1:0]     ent_idx;
	logic                 hit;
	logic                 miss_free;
	logic                 exhausted;
	logic                 full;
	logic                 ins;
	logic                 in_acc;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign sweep_last = (state_q == S_SWEEP) && (sweep_q == SLOT_W'(TABLE_SLOTS - 1));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_shift_q <= QUANT_SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			quant_shift_q <= cfg_data;
		end
	end

	// Key and slot pipeline.
	qvd_hash #(
		.FIELD_BITS(FIELD_BITS),
		.SLOT_W    (SLOT_W)
	) u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (hash_start_q),
		.pos        (pos_q),
		.quant_shift(quant_shift_q),
		.done       (hash_done),
		.key        (hash_key),
		.slot       (hash_slot)
	);

	// Table memory.
	qvd_table #(
		.SLOTS  (TABLE_SLOTS),
		.ENTRY_W(ENTRY_W)
	) u_table (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// Probe decode of the slot read in the previous cycle.
	assign {ent_valid, ent_key, ent_idx} = rd_data;
	assign hit       = ent_valid && (ent_key == key_q);
	assign miss_free = !ent_valid;
	assign exhausted = ent_valid && !hit && (probes_q == SLOT_W'(TABLE_SLOTS - 1));
	assign full      = (count_q >= CNT_W'(MAX_UNIQUE));
	assign ins       = (state_q == S_PROBE) && miss_free && !full;

	// Read address: hashed slot first, then the next slot on each probe.
	assign rd_addr = (state_q == S_PROBE) ? slot_q + 1'b1 : hash_slot;

	// Write port: invalidate during the sweep, insert on a free slot.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = {1'b1, key_q, IDX_W'(count_q)};
		if (state_q == S_SWEEP) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = '0;
		end else if (ins) begin
			wr_en = 1'b1;
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			hash_start_q <= 1'b0;
			count_q      <= '0;
			bmin_q       <= '0;
			bmax_q       <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			// A plain vertex starts hashing at once; a cleared one after its sweep.
			hash_start_q <= (in_acc && !s_tuser[0]) || (sweep_last && pos_q_pending_q);
			if (state_q == S_EMIT && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						// A sweep started by clear_table goes on to the vertex.
						state_q <= pos_q_pending_q ? S_HASH : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser[0]) begin
							state_q <= S_SWEEP;
							sweep_q <= '0;
							count_q <= '0;
							bmin_q  <= '0;
							bmax_q  <= '0;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (hit || miss_free || exhausted) begin
						state_q <= S_EMIT;
					end
					if (ins) begin
						count_q <= count_q + 1'b1;
						if (count_q == '0) begin
							bmin_q <= pos_q;
							bmax_q <= pos_q;
						end else begin
							if (pos_q.x < bmin_q.x) bmin_q.x <= pos_q.x;
							if (pos_q.y < bmin_q.y) bmin_q.y <= pos_q.y;
							if (pos_q.z < bmin_q.z) bmin_q.z <= pos_q.z;
							if (pos_q.x > bmax_q.x) bmax_q.x <= pos_q.x;
							if (pos_q.y > bmax_q.y) bmax_q.y <= pos_q.y;
							if (pos_q.z > bmax_q.z) bmax_q.z <= pos_q.z;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A vertex waits behind a clear sweep; reset's own sweep carries none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q_pending_q <= 1'b0;
		end else if (in_acc) begin
			pos_q_pending_q <= s_tuser[0];
		end else if (hash_start_q) begin
			pos_q_pending_q <= 1'b0;
		end
	end

	// Input capture and probe datapath.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q.x <= s_tdata[0*COORD_W +: COORD_W];
			pos_q.y <= s_tdata[1*COORD_W +: COORD_W];
			pos_q.z <= s_tdata[2*COORD_W +: COORD_W];
		end
		if (state_q == S_HASH && hash_done) begin
			key_q    <= hash_key;
			slot_q   <= hash_slot;
			probes_q <= '0;
		end else if (state_q == S_PROBE) begin
			slot_q   <= slot_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
		if (state_q == S_PROBE) begin
			res_idx_q <= hit ? ent_idx : (ins ? IDX_W'(count_q) : '0);
			res_new_q <= ins;
			res_ovf_q <= !hit && (exhausted || (miss_free && full));
		end
	end

	// Result beat.
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			m_tdata <= OUT_DATA_W'({bmax_q.z, bmax_q.y, bmax_q.x,
				bmin_q.z, bmin_q.y, bmin_q.x, res_ovf_q, res_new_q, res_idx_q});
		end
	end

	`QVD_NEVER(a_new_and_ovf, m_tvalid && m_tdata[IDX_W] && m_tdata[IDX_W+1], "new and overflow together")
	`QVD_NEVER(a_count_bound, count_q > CNT_W'(MAX_UNIQUE), "unique count past limit")
	`QVD_ASSERT(a_ins_counts, ins && count_q != '0 |=> count_q == $past(count_q) + 1'b1, "insert did not count")
	`QVD_NEVER(a_busy_ready, s_tready && (state_q == S_SWEEP || state_q == S_PROBE), "ready while busy")

endmodule
